>>> hw/rtl/acc_cpu_pkg.sv
// Package for the accumulator CPU core: item kinds, result status codes,
// opcodes and configuration register indexes. No dependencies.
package acc_cpu_pkg;

  localparam int KindBits   = 2;
  localparam int StatusBits = 3;
  localparam int OpBits     = 6;
  localparam int EntryBits  = 11;
  localparam int AddrBits   = 11;
  localparam int DataBits   = 32;
  localparam int RandBits   = 7;

  localparam logic [KindBits-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KindBits-1:0] KIND_EXEC  = 2'd1;
  localparam logic [KindBits-1:0] KIND_TIMER = 2'd2;

  localparam logic [StatusBits-1:0] STS_EXEC    = 3'd0;
  localparam logic [StatusBits-1:0] STS_END     = 3'd1;
  localparam logic [StatusBits-1:0] STS_INVALID = 3'd2;
  localparam logic [StatusBits-1:0] STS_FAULT   = 3'd3;
  localparam logic [StatusBits-1:0] STS_HALTED  = 3'd4;
  localparam logic [StatusBits-1:0] STS_LOADED  = 3'd5;
  localparam logic [StatusBits-1:0] STS_TIMER   = 3'd6;
  localparam logic [StatusBits-1:0] STS_IGNORED = 3'd7;

  localparam logic CFG_INT_ENTRY   = 1'b0;
  localparam logic CFG_TIMER_ENTRY = 1'b1;

  localparam logic [OpBits-1:0] OP_NONE   = 6'd0;
  localparam logic [OpBits-1:0] OP_LDVAL  = 6'd1;
  localparam logic [OpBits-1:0] OP_LOAD   = 6'd2;
  localparam logic [OpBits-1:0] OP_LDIND  = 6'd3;
  localparam logic [OpBits-1:0] OP_LDIDXX = 6'd4;
  localparam logic [OpBits-1:0] OP_LDIDXY = 6'd5;
  localparam logic [OpBits-1:0] OP_LDSPX  = 6'd6;
  localparam logic [OpBits-1:0] OP_STORE  = 6'd7;
  localparam logic [OpBits-1:0] OP_GET    = 6'd8;
  localparam logic [OpBits-1:0] OP_PUT    = 6'd9;
  localparam logic [OpBits-1:0] OP_ADDX   = 6'd10;
  localparam logic [OpBits-1:0] OP_ADDY   = 6'd11;
  localparam logic [OpBits-1:0] OP_SUBX   = 6'd12;
  localparam logic [OpBits-1:0] OP_SUBY   = 6'd13;
  localparam logic [OpBits-1:0] OP_TOX    = 6'd14;
  localparam logic [OpBits-1:0] OP_FROMX  = 6'd15;
  localparam logic [OpBits-1:0] OP_TOY    = 6'd16;
  localparam logic [OpBits-1:0] OP_FROMY  = 6'd17;
  localparam logic [OpBits-1:0] OP_TOSP   = 6'd18;
  localparam logic [OpBits-1:0] OP_FROMSP = 6'd19;
  localparam logic [OpBits-1:0] OP_JUMP   = 6'd20;
  localparam logic [OpBits-1:0] OP_JEQ    = 6'd21;
  localparam logic [OpBits-1:0] OP_JNE    = 6'd22;
  localparam logic [OpBits-1:0] OP_CALL   = 6'd23;
  localparam logic [OpBits-1:0] OP_RET    = 6'd24;
  localparam logic [OpBits-1:0] OP_INCX   = 6'd25;
  localparam logic [OpBits-1:0] OP_DECX   = 6'd26;
  localparam logic [OpBits-1:0] OP_PUSH   = 6'd27;
  localparam logic [OpBits-1:0] OP_POP    = 6'd28;
  localparam logic [OpBits-1:0] OP_INT    = 6'd29;
  localparam logic [OpBits-1:0] OP_IRET   = 6'd30;
  localparam logic [OpBits-1:0] OP_END    = 6'd50;

  localparam logic [EntryBits-1:0] IntEntryReset   = 11'd1536;
  localparam logic [EntryBits-1:0] TimerEntryReset = 11'd1024;

endpackage

>>> hw/rtl/accumulator_cpu_core.sv
// Accumulator CPU core top level: sequencer, register file, word memory.
// Depends on acc_cpu_pkg.
//
// A transaction starts when start is high and busy is low; its single result appears for one
// cycle on the result ports, marked by done_o, and cannot be held off by the receiver. Load-word,
// halted, ignored-timer and unused-kind items finish in the cycle they are accepted and show
// their result in the next, as does an instruction whose fetch address faults. Any other
// instruction spends one state on each access that it makes to the single-port word memory
// (fetch, operand, pointer, data, and the second stack word of IRet); with interrupts enabled,
// Int and the timer interrupt write two stack words in two states. The result is shown in the
// cycle after the last state, which may overlap the start of the next transaction.
module accumulator_cpu_core #(
  parameter int MEM_DEPTH   = 2048,
  parameter int SYSTEM_BASE = 1024,
  parameter int WORD_BITS   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [acc_cpu_pkg::KindBits-1:0]     kind_i,
  input  logic [acc_cpu_pkg::AddrBits-1:0]     address_i,
  input  logic signed [acc_cpu_pkg::DataBits-1:0] data_i,
  input  logic [acc_cpu_pkg::RandBits-1:0]     random_value_i,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [acc_cpu_pkg::EntryBits-1:0]    cfg_data_i,
  output logic                                 done_o,
  output logic [acc_cpu_pkg::StatusBits-1:0]   status_o,
  output logic signed [acc_cpu_pkg::DataBits-1:0] next_pc_o,
  output logic signed [acc_cpu_pkg::DataBits-1:0] acc_value_o,
  output logic                                 port_valid_o,
  output logic [1:0]                           port_number_o,
  output logic signed [acc_cpu_pkg::DataBits-1:0] port_value_o
);
  import acc_cpu_pkg::*;

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int W  = WORD_BITS;
  localparam logic [W-1:0] StackTop = W'(MEM_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_OPND, S_PTR, S_LAST, S_IRET2, S_INT2
  } state_e;

  state_e state_q, state_d;
  logic [W-1:0] pc_q, pc_d, ac_q, ac_d, x_q, x_d, y_q, y_d, sp_q, sp_d;
  logic kern_q, kern_d, ie_q, ie_d, halt_q, halt_d;
  logic [EntryBits-1:0] int_entry_q, timer_entry_q, ent_q, ent_d;
  logic [OpBits-1:0] op_q, op_d, opc;
  logic [W-1:0] ret_q, ret_d;
  logic [RandBits-1:0] rnd_q, rnd_d;
  logic done_q, done_d;
  logic [StatusBits-1:0] status_q, status_d;
  logic pv_q, pv_d;
  logic [1:0] pn_q, pn_d;
  logic [DataBits-1:0] pval_q, pval_d;

  logic [W-1:0] mem [MEM_DEPTH];
  logic [W-1:0] rdata_q, mem_wdata;
  logic [AW-1:0] mem_addr;
  logic mem_we;

  logic [W-1:0] add_a, add_b, add_y, p1, p2;
  logic add_sub;

  function automatic logic addr_ok(input logic [W-1:0] a, input logic k);
    logic [W:0] ax;
    ax = {1'b0, a};
    addr_ok = !a[W-1] && (ax < (W+1)'(MEM_DEPTH)) && (k || (ax < (W+1)'(SYSTEM_BASE)));
  endfunction

  assign busy = (state_q != S_IDLE);
  assign p1 = pc_q + W'(1);
  assign p2 = pc_q + W'(2);
  assign opc = (rdata_q[W-1:OpBits] == '0) ? rdata_q[OpBits-1:0] : OP_NONE;
  assign add_y = add_sub ? (add_a - add_b) : (add_a + add_b);

  // Operand selection for the shared adder.
  always_comb begin
    add_a = sp_q;
    add_b = W'(1);
    add_sub = 1'b0;
    case (state_q)
      S_DECODE: begin
        case (opc)
          OP_LDSPX: add_b = x_q;
          OP_ADDX: begin add_a = ac_q; add_b = x_q; end
          OP_ADDY: begin add_a = ac_q; add_b = y_q; end
          OP_SUBX: begin add_a = ac_q; add_b = x_q; add_sub = 1'b1; end
          OP_SUBY: begin add_a = ac_q; add_b = y_q; add_sub = 1'b1; end
          OP_INCX: add_a = x_q;
          OP_DECX: begin add_a = x_q; add_sub = 1'b1; end
          OP_PUSH: add_sub = 1'b1;
          default: add_b = W'(1);
        endcase
      end
      S_OPND: begin
        case (op_q)
          OP_LDIDXX: begin add_a = rdata_q; add_b = x_q; end
          OP_LDIDXY: begin add_a = rdata_q; add_b = y_q; end
          OP_CALL: add_sub = 1'b1;
          default: add_b = W'(1);
        endcase
      end
      S_LAST: begin
        if (op_q == OP_IRET) begin
          add_b = W'(2);
        end
      end
      default: add_b = W'(1);
    endcase
  end

  always_comb begin
    state_d = state_q;
    pc_d = pc_q; ac_d = ac_q; x_d = x_q; y_d = y_q; sp_d = sp_q;
    kern_d = kern_q; ie_d = ie_q; halt_d = halt_q;
    ent_d = ent_q; op_d = op_q; ret_d = ret_q; rnd_d = rnd_q;
    done_d = 1'b0; status_d = status_q;
    pv_d = 1'b0; pn_d = 2'd0; pval_d = '0;
    mem_we = 1'b0; mem_addr = pc_q[AW-1:0]; mem_wdata = ac_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          rnd_d = random_value_i;
          done_d = 1'b1;
          case (kind_i)
            KIND_LOAD: begin
              status_d = STS_LOADED;
              if (32'(address_i) < 32'(MEM_DEPTH)) begin
                mem_we = 1'b1;
                mem_addr = AW'(address_i);
                mem_wdata = W'({{32{data_i[DataBits-1]}}, data_i});
              end
            end
            KIND_EXEC: begin
              if (halt_q) begin
                status_d = STS_HALTED;
              end else if (!addr_ok(pc_q, kern_q)) begin
                status_d = STS_FAULT; halt_d = 1'b1;
              end else begin
                done_d = 1'b0;
                state_d = S_DECODE;
              end
            end
            KIND_TIMER: begin
              if (halt_q) begin
                status_d = STS_HALTED;
              end else if (!ie_q) begin
                status_d = STS_IGNORED;
              end else begin
                done_d = 1'b0;
                status_d = STS_TIMER;
                mem_we = 1'b1; mem_addr = StackTop[AW-1:0]; mem_wdata = sp_q;
                ret_d = pc_q; ent_d = timer_entry_q;
                state_d = S_INT2;
              end
            end
            default: status_d = STS_INVALID;
          endcase
        end
      end
      S_DECODE: begin
        op_d = opc;
        status_d = STS_EXEC;
        done_d = 1'b1;
        state_d = S_IDLE;
        case (opc)
          OP_LDVAL, OP_LOAD, OP_LDIND, OP_LDIDXX, OP_LDIDXY, OP_STORE, OP_PUT,
          OP_JUMP, OP_JEQ, OP_JNE, OP_CALL: begin
            if (addr_ok(p1, kern_q)) begin
              mem_addr = p1[AW-1:0]; done_d = 1'b0; state_d = S_OPND;
            end else begin
              status_d = STS_FAULT; halt_d = 1'b1;
            end
          end
          OP_LDSPX, OP_RET, OP_POP, OP_IRET: begin
            if (addr_ok(add_y, kern_q)) begin
              mem_addr = add_y[AW-1:0]; done_d = 1'b0; state_d = S_LAST;
            end else begin
              status_d = STS_FAULT; halt_d = 1'b1;
            end
          end
          OP_GET: begin ac_d = W'(rnd_q); pc_d = p1; end
          OP_ADDX, OP_ADDY, OP_SUBX, OP_SUBY: begin ac_d = add_y; pc_d = p1; end
          OP_TOX: begin x_d = ac_q; pc_d = p1; end
          OP_FROMX: begin ac_d = x_q; pc_d = p1; end
          OP_TOY: begin y_d = ac_q; pc_d = p1; end
          OP_FROMY: begin ac_d = y_q; pc_d = p1; end
          OP_TOSP: begin sp_d = ac_q; pc_d = p1; end
          OP_FROMSP: begin ac_d = sp_q; pc_d = p1; end
          OP_INCX, OP_DECX: begin x_d = add_y; pc_d = p1; end
          OP_PUSH: begin
            if (addr_ok(sp_q, kern_q)) begin
              mem_we = 1'b1; mem_addr = sp_q[AW-1:0]; mem_wdata = ac_q;
              sp_d = add_y; pc_d = p1;
            end else begin
              status_d = STS_FAULT; halt_d = 1'b1;
            end
          end
          OP_INT: begin
            if (ie_q) begin
              mem_we = 1'b1; mem_addr = StackTop[AW-1:0]; mem_wdata = sp_q;
              ret_d = p1; ent_d = int_entry_q;
              done_d = 1'b0; state_d = S_INT2;
            end else begin
              pc_d = p1;
            end
          end
          OP_END: begin status_d = STS_END; halt_d = 1'b1; end
          default: status_d = STS_INVALID;
        endcase
      end
      S_OPND: begin
        ret_d = rdata_q;
        status_d = STS_EXEC;
        done_d = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          OP_LDVAL: begin ac_d = rdata_q; pc_d = p2; end
          OP_LOAD, OP_LDIND: begin
            if (addr_ok(rdata_q, kern_q)) begin
              mem_addr = rdata_q[AW-1:0]; done_d = 1'b0;
              state_d = (op_q == OP_LDIND) ? S_PTR : S_LAST;
            end else begin
              status_d = STS_FAULT; halt_d = 1'b1;
            end
          end
          OP_LDIDXX, OP_LDIDXY: begin
            if (addr_ok(add_y, kern_q)) begin
              mem_addr = add_y[AW-1:0]; done_d = 1'b0; state_d = S_LAST;
            end else begin
              status_d = STS_FAULT; halt_d = 1'b1;
            end
          end
          OP_STORE: begin
            if (addr_ok(rdata_q, kern_q)) begin
              mem_we = 1'b1; mem_addr = rdata_q[AW-1:0]; mem_wdata = ac_q; pc_d = p2;
            end else begin
              status_d = STS_FAULT; halt_d = 1'b1;
            end
          end
          OP_PUT: begin
            pc_d = p2;
            if (rdata_q == W'(1) || rdata_q == W'(2)) begin
              pv_d = 1'b1; pn_d = rdata_q[1:0]; pval_d = DataBits'(ac_q);
            end
          end
          OP_JUMP: pc_d = rdata_q;
          OP_JEQ: pc_d = (ac_q == '0) ? rdata_q : p2;
          OP_JNE: pc_d = (ac_q != '0) ? rdata_q : p2;
          OP_CALL: begin
            if (addr_ok(sp_q, kern_q)) begin
              mem_we = 1'b1; mem_addr = sp_q[AW-1:0]; mem_wdata = p2;
              sp_d = add_y; pc_d = rdata_q;
            end else begin
              status_d = STS_FAULT; halt_d = 1'b1;
            end
          end
          default: status_d = STS_INVALID;
        endcase
      end
      S_PTR: begin
        if (addr_ok(rdata_q, kern_q)) begin
          mem_addr = rdata_q[AW-1:0]; state_d = S_LAST;
        end else begin
          status_d = STS_FAULT; halt_d = 1'b1; done_d = 1'b1; state_d = S_IDLE;
        end
      end
      S_LAST: begin
        status_d = STS_EXEC;
        done_d = 1'b1;
        state_d = S_IDLE;
        case (op_q)
          OP_LDSPX: begin ac_d = rdata_q; pc_d = p1; end
          OP_POP: begin ac_d = rdata_q; sp_d = add_y; pc_d = p1; end
          OP_RET: begin pc_d = rdata_q; sp_d = add_y; end
          OP_IRET: begin
            ret_d = rdata_q;
            if (addr_ok(add_y, kern_q)) begin
              mem_addr = add_y[AW-1:0]; done_d = 1'b0; state_d = S_IRET2;
            end else begin
              status_d = STS_FAULT; halt_d = 1'b1;
            end
          end
          default: begin ac_d = rdata_q; pc_d = p2; end
        endcase
      end
      S_IRET2: begin
        pc_d = ret_q; sp_d = rdata_q; ie_d = 1'b1; kern_d = 1'b0;
        done_d = 1'b1; state_d = S_IDLE;
      end
      S_INT2: begin
        mem_we = 1'b1; mem_addr = StackTop[AW-1:0] - AW'(1); mem_wdata = ret_q;
        sp_d = StackTop - W'(1) - W'(1);
        kern_d = 1'b1; ie_d = 1'b0; pc_d = W'(ent_q);
        done_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q <= '0; ac_q <= '0; x_q <= '0; y_q <= '0;
      sp_q <= W'(SYSTEM_BASE - 1);
      kern_q <= 1'b0; ie_q <= 1'b1; halt_q <= 1'b0;
      int_entry_q <= IntEntryReset; timer_entry_q <= TimerEntryReset;
      done_q <= 1'b0; status_q <= STS_EXEC;
      pv_q <= 1'b0; pn_q <= 2'd0; pval_q <= '0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d; ac_q <= ac_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d;
      kern_q <= kern_d; ie_q <= ie_d; halt_q <= halt_d;
      done_q <= done_d; status_q <= status_d;
      pv_q <= pv_d; pn_q <= pn_d; pval_q <= pval_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_INT_ENTRY) begin
          int_entry_q <= cfg_data_i;
        end else begin
          timer_entry_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d; op_q <= op_d; ret_q <= ret_d; rnd_q <= rnd_d;
  end

  assign done_o = done_q;
  assign status_o = status_q;
  assign next_pc_o = DataBits'(pc_q);
  assign acc_value_o = DataBits'(ac_q);
  assign port_valid_o = pv_q;
  assign port_number_o = pn_q;
  assign port_value_o = pval_q;

`ifndef SYNTH
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither busy nor finished");
  a_halt_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halt_q) |-> (done_o && (status_o == STS_FAULT || status_o == STS_END)))
    else $error("core halted without fault or end result");
  a_port_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    port_valid_o |-> (done_o && status_o == STS_EXEC))
    else $error("port output outside an executed instruction");
  a_kernel_irq_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INT2) |=> (kern_q && !ie_q && done_o))
    else $error("interrupt entry did not switch to kernel mode");
`endif

endmodule
